// File: rtl/bsrw_pkg.sv
// ---------------------------------------------------------------------------
// bsrw_pkg
// Types, constants and helper functions shared by the bit stream reader and
// writer: action and status codes, beat layouts, controller commands.
// ---------------------------------------------------------------------------
package bsrw_pkg;

	localparam int MAX_BITS  = 32;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 6;
	localparam int SB_W      = 13;
	localparam int MODE_W    = 2;
	localparam int BADDR_W   = 12;
	localparam int BYTE_W    = 8;
	localparam int POS_OUT_W = 16;
	localparam int STAT_W    = 2;
	localparam int ACT_W     = 3;

	// up to 32 bits at any bit offset span at most five bytes
	localparam int WIN_BYTES = 5;
	localparam int WIN_W     = WIN_BYTES * BYTE_W;
	localparam int IDX_W     = 3;

	// input beat layout
	localparam int S_TDATA_W   = 64;
	localparam int IN_CNT_LSB  = 0;
	localparam int IN_DATA_LSB = IN_CNT_LSB + CNT_W;
	localparam int IN_ADDR_LSB = IN_DATA_LSB + DATA_W;
	localparam int IN_BVAL_LSB = IN_ADDR_LSB + BADDR_W;
	localparam int IN_USED_W   = IN_BVAL_LSB + BYTE_W;

	// output beat layout
	localparam int M_TDATA_W = DATA_W + CNT_W + STAT_W + BYTE_W + POS_OUT_W;

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] CFG_STREAM_BYTES = 1'b0;
	localparam logic [REG_IDX_W-1:0] CFG_ACCESS_MODE  = 1'b1;

	localparam logic [SB_W-1:0]   STREAM_BYTES_RST = '0;
	localparam logic [MODE_W-1:0] MODE_RD_ONLY     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WR_ONLY     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOTH        = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_RD_LSB  = 3'd0,
		ACT_RD_MSB  = 3'd1,
		ACT_WR_LSB  = 3'd2,
		ACT_WR_MSB  = 3'd3,
		ACT_FLUSH   = 3'd4,
		ACT_RESTART = 3'd5,
		ACT_LOAD    = 3'd6,
		ACT_FETCH   = 3'd7
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FORBIDDEN = 2'd1,
		STAT_FLUSH_END = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_RD,
		S_XFER,
		S_WR,
		S_LOAD,
		S_FETCH,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             latch;
		logic             plan;
		logic             rd_en;
		logic             cap_en;
		logic             xfer;
		logic             wr_en;
		logic             load;
		logic             fetch;
		logic             finish;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] cap_idx;
	} cmd_t;

	typedef struct packed {
		action_t          action;
		logic [IDX_W-1:0] nbytes;
	} sts_t;

	function automatic logic [DATA_W-1:0] rev_bits(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		for (int i = 0; i < DATA_W; i++) begin
			r[i] = v[DATA_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [DATA_W:0] m;
		m = ((DATA_W+1)'(1) << n) - (DATA_W+1)'(1);
		return m[DATA_W-1:0];
	endfunction

endpackage

// File: rtl/bit_stream_reader_writer.sv
// ---------------------------------------------------------------------------
// bit_stream_reader_writer
// Reads and writes 0 to 32 bits at a bit position in a byte store, least or
// most significant bit first, with flush, restart, and byte load and fetch.
// ---------------------------------------------------------------------------
// usage:
//  s_* channel takes one command per beat; s_tuser selects the action, one
//  result beat on m_* comes back for every command, in order.
//  configuration (stream length, access mode) is written through cfg_we,
//  cfg_addr and cfg_wdata while no command is in flight.
//  the single store port makes one byte access a cycle; with nb the bytes
//  the transfer spans (0 to 5), a read reads nb bytes into the window, a
//  write reads them, merges and writes them back; flush and restart go
//  straight to the result, load and fetch make one store access;
//  a read or write that moves no bits (nb 0) skips the store.
//  one command is worked on at a time; the next beat is taken in the cycle
//  after the result is registered, also while that result waits.
//  if m_tready is low the result stays in the output register and the
//  following command holds in its last step until the register frees.
//  reset clears the position and the handshakes, sets stream length 0 and
//  access mode both; store bytes are undefined until loaded or written.
// ---------------------------------------------------------------------------
module bit_stream_reader_writer #(
	parameter int STORE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsrw_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [bsrw_pkg::SB_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// bit_count, data_in, byte_address, byte_value, zero pad
	input  logic [bsrw_pkg::S_TDATA_W-1:0]  s_tdata,
	// action
	input  logic [bsrw_pkg::ACT_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// data_out, bits_short, status, byte_out, position
	output logic [bsrw_pkg::M_TDATA_W-1:0]  m_tdata
);

	bsrw_pkg::cmd_t cmd;
	bsrw_pkg::sts_t sts;

	bsrw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bsrw_dp #(
		.STORE_BYTES(STORE_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tdata  (m_tdata)
	);

endmodule

// File: rtl/bsrw_ram.sv
// ---------------------------------------------------------------------------
// bsrw_ram
// Single port RAM, one access a cycle, registered read data.
// ---------------------------------------------------------------------------
module bsrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/bsrw_dp.sv
// ---------------------------------------------------------------------------
// bsrw_dp
// Datapath: configuration registers, bit position, byte store, five byte
// window for gathering and merging bits, and the result register.
// ---------------------------------------------------------------------------
module bsrw_dp #(
	parameter int STORE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsrw_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [bsrw_pkg::SB_W-1:0]       cfg_wdata,
	input  logic [bsrw_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [bsrw_pkg::ACT_W-1:0]      s_tuser,
	input  bsrw_pkg::cmd_t                  cmd,
	output bsrw_pkg::sts_t                  sts,
	output logic [bsrw_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int AW    = $clog2(STORE_BYTES);
	localparam int LEN_W = $clog2(STORE_BYTES + 1);
	localparam int POS_W = LEN_W + 3;
	localparam int CMP_W = (LEN_W > bsrw_pkg::SB_W) ? LEN_W : bsrw_pkg::SB_W;
	localparam int DW    = bsrw_pkg::DATA_W;
	localparam int CW    = bsrw_pkg::CNT_W;

	logic [bsrw_pkg::SB_W-1:0]   stream_bytes_q;
	logic [bsrw_pkg::MODE_W-1:0] access_mode_q;
	logic [POS_W-1:0]            pos_q;

	bsrw_pkg::action_t           act_q;
	logic [CW-1:0]               cnt_q;
	logic [DW-1:0]               data_q;
	logic [bsrw_pkg::BADDR_W-1:0] addr_q;
	logic [bsrw_pkg::BYTE_W-1:0] bval_q;
	logic [DW-1:0]               wsrc_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               short_q;
	logic [bsrw_pkg::WIN_W-1:0]  win_q;
	logic [DW-1:0]               g_q;
	logic [bsrw_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [CW-1:0]    cnt_in;
	logic [LEN_W-1:0] len;
	logic [POS_W-1:0] endb;
	logic [POS_W-1:0] avail;
	logic [POS_W-1:0] pos_rnd;
	logic [POS_W-1:0] pos_next;
	logic             at_end;
	logic             is_rd;
	logic             is_wr;
	logic             forbid;
	logic             addr_ok;
	logic [CW-1:0]    n_c;
	logic [6:0]       nb_sum;
	logic [bsrw_pkg::IDX_W-1:0] nb_c;
	logic [bsrw_pkg::WIN_W-1:0] shifted;
	logic [bsrw_pkg::WIN_W-1:0] wwin;
	logic [DW-1:0]    dout_c;
	logic [bsrw_pkg::BYTE_W-1:0] bout_c;
	bsrw_pkg::status_t stat_c;
	logic [LEN_W:0]   rw_sum;
	logic [AW-1:0]    ram_addr;
	logic             ram_en;
	logic             ram_we;
	logic [bsrw_pkg::BYTE_W-1:0] ram_wdata;
	logic [bsrw_pkg::BYTE_W-1:0] ram_rdata;

	// stream end, available bits, access check, clamped bit count and byte span, stable until the position moves at finish
	always_comb begin
		cnt_in = s_tdata[bsrw_pkg::IN_CNT_LSB +: CW];
		len = (CMP_W'(stream_bytes_q) > CMP_W'(STORE_BYTES)) ? LEN_W'(STORE_BYTES)
		                                                     : LEN_W'(stream_bytes_q);
		endb = {len, 3'b000};
		at_end = (pos_q >= endb);
		avail = endb - pos_q;
		is_rd = (act_q == bsrw_pkg::ACT_RD_LSB) || (act_q == bsrw_pkg::ACT_RD_MSB);
		is_wr = (act_q == bsrw_pkg::ACT_WR_LSB) || (act_q == bsrw_pkg::ACT_WR_MSB);
		forbid = (is_rd && (access_mode_q == bsrw_pkg::MODE_WR_ONLY)) ||
		         (is_wr && (access_mode_q == bsrw_pkg::MODE_RD_ONLY));
		addr_ok = (32'(addr_q) < 32'(STORE_BYTES));
		if (!(is_rd || is_wr) || forbid || at_end) begin
			n_c = '0;
		end else if (avail < POS_W'(cnt_q)) begin
			n_c = CW'(avail);
		end else begin
			n_c = cnt_q;
		end
		nb_sum = 7'(pos_q[2:0]) + 7'(n_c) + 7'd7;
		nb_c = (n_c == '0) ? '0 : bsrw_pkg::IDX_W'(nb_sum >> 3);
	end

	assign sts.action = act_q;
	assign sts.nbytes = nb_c;

	// store port: load and fetch by address, window bytes from the position
	always_comb begin
		rw_sum = {1'b0, pos_q[POS_W-1:3]} + (LEN_W+1)'(cmd.idx);
		if (cmd.load || cmd.fetch) begin
			ram_addr = AW'(addr_q);
		end else begin
			ram_addr = AW'(rw_sum);
		end
		ram_we = (cmd.load && addr_ok) || cmd.wr_en;
		ram_en = ram_we || cmd.rd_en || cmd.fetch;
		ram_wdata = cmd.load ? bval_q : win_q[cmd.idx*bsrw_pkg::BYTE_W +: bsrw_pkg::BYTE_W];
	end

	bsrw_ram #(
		.WIDTH(bsrw_pkg::BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// extraction and merge at the bit offset
	always_comb begin
		shifted = win_q >> pos_q[2:0];
		wwin = bsrw_pkg::WIN_W'(wsrc_q & bsrw_pkg::low_mask(n_q)) << pos_q[2:0];
	end

	// result fields
	always_comb begin
		pos_rnd = (pos_q + POS_W'(7)) & ~POS_W'(7);
		pos_next = pos_q;
		dout_c = '0;
		bout_c = '0;
		stat_c = bsrw_pkg::STAT_OK;
		case (act_q)
			bsrw_pkg::ACT_RD_LSB: begin
				if (forbid) begin
					stat_c = bsrw_pkg::STAT_FORBIDDEN;
				end else begin
					dout_c = g_q;
				end
				pos_next = pos_q + POS_W'(n_q);
			end
			bsrw_pkg::ACT_RD_MSB: begin
				if (forbid) begin
					stat_c = bsrw_pkg::STAT_FORBIDDEN;
				end else begin
					dout_c = (data_q << n_q) | (bsrw_pkg::rev_bits(g_q) >> (CW'(DW) - n_q));
				end
				pos_next = pos_q + POS_W'(n_q);
			end
			bsrw_pkg::ACT_WR_LSB, bsrw_pkg::ACT_WR_MSB: begin
				if (forbid) begin
					stat_c = bsrw_pkg::STAT_FORBIDDEN;
				end
				pos_next = pos_q + POS_W'(n_q);
			end
			bsrw_pkg::ACT_FLUSH: begin
				if (at_end) begin
					stat_c = bsrw_pkg::STAT_FLUSH_END;
				end else begin
					pos_next = pos_rnd;
				end
			end
			bsrw_pkg::ACT_RESTART: begin
				pos_next = '0;
			end
			bsrw_pkg::ACT_FETCH: begin
				if (addr_ok) begin
					bout_c = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_bytes_q <= bsrw_pkg::STREAM_BYTES_RST;
			access_mode_q  <= bsrw_pkg::MODE_BOTH;
			pos_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					bsrw_pkg::CFG_STREAM_BYTES: stream_bytes_q <= cfg_wdata;
					bsrw_pkg::CFG_ACCESS_MODE:  access_mode_q <= cfg_wdata[bsrw_pkg::MODE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q  <= bsrw_pkg::action_t'(s_tuser);
			cnt_q  <= (cnt_in > CW'(bsrw_pkg::MAX_BITS)) ? CW'(bsrw_pkg::MAX_BITS) : cnt_in;
			data_q <= s_tdata[bsrw_pkg::IN_DATA_LSB +: DW];
			addr_q <= s_tdata[bsrw_pkg::IN_ADDR_LSB +: bsrw_pkg::BADDR_W];
			bval_q <= s_tdata[bsrw_pkg::IN_BVAL_LSB +: bsrw_pkg::BYTE_W];
		end
		if (cmd.plan) begin
			n_q     <= n_c;
			short_q <= ((is_rd || is_wr) && !forbid) ? (cnt_q - n_c) : '0;
			// msb-first write sends bit count-1 of the value first
			wsrc_q  <= (act_q == bsrw_pkg::ACT_WR_MSB)
			           ? (bsrw_pkg::rev_bits(data_q) >> (CW'(DW) - cnt_q)) : data_q;
		end
		if (cmd.cap_en) begin
			win_q[cmd.cap_idx*bsrw_pkg::BYTE_W +: bsrw_pkg::BYTE_W] <= ram_rdata;
		end
		if (cmd.xfer) begin
			g_q <= shifted[DW-1:0] & bsrw_pkg::low_mask(n_q);
			if (is_wr) begin
				win_q <= win_q | wwin;
			end
		end
		if (cmd.finish) begin
			m_tdata_q <= {bsrw_pkg::POS_OUT_W'(pos_next), bout_c, stat_c, short_q, dout_c};
		end
	end

	assign m_tdata = m_tdata_q;

endmodule

// File: rtl/bsrw_ctrl.sv
// ---------------------------------------------------------------------------
// bsrw_ctrl
// Controller: sequences the byte reads, the merge and the write-back of one
// item, the load and fetch accesses, and owns the handshakes of both channels.
// ---------------------------------------------------------------------------
module bsrw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  bsrw_pkg::sts_t sts,
	output bsrw_pkg::cmd_t cmd
);

	bsrw_pkg::state_t state_q, state_d;
	logic [bsrw_pkg::IDX_W-1:0] k_q, k_d;
	logic out_valid_q;
	logic is_wr;

	assign is_wr = (sts.action == bsrw_pkg::ACT_WR_LSB) || (sts.action == bsrw_pkg::ACT_WR_MSB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsrw_pkg::S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			bsrw_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d = bsrw_pkg::S_PLAN;
				end
			end
			bsrw_pkg::S_PLAN: begin
				cmd.plan = 1'b1;
				k_d = '0;
				case (sts.action)
					bsrw_pkg::ACT_RD_LSB, bsrw_pkg::ACT_RD_MSB,
					bsrw_pkg::ACT_WR_LSB, bsrw_pkg::ACT_WR_MSB: begin
						state_d = (sts.nbytes == '0) ? bsrw_pkg::S_XFER : bsrw_pkg::S_RD;
					end
					bsrw_pkg::ACT_LOAD:  state_d = bsrw_pkg::S_LOAD;
					bsrw_pkg::ACT_FETCH: state_d = bsrw_pkg::S_FETCH;
					default:             state_d = bsrw_pkg::S_FIN;
				endcase
			end
			bsrw_pkg::S_RD: begin
				// issue byte k, capture byte k-1 from the registered read
				cmd.idx = k_q;
				cmd.cap_idx = k_q - bsrw_pkg::IDX_W'(1);
				cmd.rd_en = (k_q < sts.nbytes);
				cmd.cap_en = (k_q != '0);
				if (k_q == sts.nbytes) begin
					k_d = '0;
					state_d = bsrw_pkg::S_XFER;
				end else begin
					k_d = k_q + bsrw_pkg::IDX_W'(1);
				end
			end
			bsrw_pkg::S_XFER: begin
				cmd.xfer = 1'b1;
				k_d = '0;
				state_d = (is_wr && (sts.nbytes != '0)) ? bsrw_pkg::S_WR : bsrw_pkg::S_FIN;
			end
			bsrw_pkg::S_WR: begin
				cmd.wr_en = 1'b1;
				cmd.idx = k_q;
				if (k_q == sts.nbytes - bsrw_pkg::IDX_W'(1)) begin
					k_d = '0;
					state_d = bsrw_pkg::S_FIN;
				end else begin
					k_d = k_q + bsrw_pkg::IDX_W'(1);
				end
			end
			bsrw_pkg::S_LOAD: begin
				cmd.load = 1'b1;
				state_d = bsrw_pkg::S_FIN;
			end
			bsrw_pkg::S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = bsrw_pkg::S_FIN;
			end
			bsrw_pkg::S_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d = bsrw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bsrw_pkg::S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result written over a beat not yet taken");

	a_accept_plans: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == bsrw_pkg::S_PLAN))
		else $error("accepted item not planned");

	a_rd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsrw_pkg::S_RD) |->
		(k_q <= sts.nbytes) && (sts.nbytes <= bsrw_pkg::IDX_W'(bsrw_pkg::WIN_BYTES)))
		else $error("byte read counter out of range");

	a_wr_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsrw_pkg::S_WR) |-> (sts.nbytes != '0) && (k_q < sts.nbytes))
		else $error("write-back with no byte to write");

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish)
		else $error("two results for one item");

endmodule

// File: verif/bsrw_scoreboard.sv
// ---------------------------------------------------------------------------
// bsrw_scoreboard
// Watches the configuration port and both stream channels of the bit stream
// reader and writer, keeps its own copy of the byte store, position and
// registers, predicts the result beat of every accepted command and compares
// each result beat with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module bsrw_scoreboard #(
	parameter int STORE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsrw_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [bsrw_pkg::SB_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bsrw_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [bsrw_pkg::ACT_W-1:0]      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bsrw_pkg::M_TDATA_W-1:0]  m_tdata,
	output int                              fail_count,
	output int                              pending,
	output int                              bit_pos,
	output int                              n_checked,
	output int                              n_short,
	output int                              n_forbid,
	output int                              n_flush_end
);
	import bsrw_pkg::*;

	// same layout as m_tdata, lowest field last
	typedef struct packed {
		logic [POS_OUT_W-1:0] position;
		logic [BYTE_W-1:0]    byte_out;
		logic [STAT_W-1:0]    status;
		logic [CNT_W-1:0]     bits_short;
		logic [DATA_W-1:0]    data_out;
	} result_beat_t;

	logic [BYTE_W-1:0] store_mem [STORE_BYTES];
	int unsigned       cursor = 0;
	logic [SB_W-1:0]   stream_len = STREAM_BYTES_RST;
	logic [MODE_W-1:0] mode = MODE_BOTH;
	result_beat_t      results_due [$];
	result_beat_t      due, fresh, got;

	int errors = 0;
	int checked = 0;
	int short_hits = 0;
	int forbid_hits = 0;
	int flush_end_hits = 0;
	int outstanding = 0;

	assign fail_count  = errors;
	assign n_checked   = checked;
	assign n_short     = short_hits;
	assign n_forbid    = forbid_hits;
	assign n_flush_end = flush_end_hits;
	assign bit_pos     = cursor;
	assign pending     = outstanding;

	task automatic report(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] seen,
			input logic [DATA_W-1:0] want);
		if (seen !== want) begin
			report($sformatf("result %0d: %s is %h, expected %h", checked, name, seen, want));
		end
	endtask

	function automatic int unsigned stream_end_bit();
		int unsigned len;
		len = (stream_len > STORE_BYTES) ? STORE_BYTES : stream_len;
		return len << 3;
	endfunction

	// applies one command to the local store and position, returns its result
	function automatic result_beat_t bitstream_step(input action_t act,
			input logic [CNT_W-1:0] cnt_in, input logic [DATA_W-1:0] din,
			input logic [BADDR_W-1:0] addr, input logic [BYTE_W-1:0] bval);
		result_beat_t r;
		int unsigned  n, i, endb;
		logic         b;
		r = '0;
		endb = stream_end_bit();
		n = (cnt_in > MAX_BITS) ? MAX_BITS : cnt_in;
		i = 0;
		case (act)
			ACT_RD_LSB, ACT_RD_MSB: begin
				if (mode == MODE_WR_ONLY) begin
					r.status = STAT_FORBIDDEN;
				end else begin
					// msb-first shifts into the caller's value
					if (act == ACT_RD_MSB) r.data_out = din;
					while (i < n && cursor < endb) begin
						b = store_mem[cursor >> 3][cursor[2:0]];
						if (act == ACT_RD_LSB) r.data_out[i] = b;
						else r.data_out = {r.data_out[DATA_W-2:0], b};
						cursor++;
						i++;
					end
					r.bits_short = CNT_W'(n - i);
				end
			end
			ACT_WR_LSB, ACT_WR_MSB: begin
				if (mode == MODE_RD_ONLY) begin
					r.status = STAT_FORBIDDEN;
				end else begin
					while (i < n && cursor < endb) begin
						b = (act == ACT_WR_LSB) ? din[i] : din[n-1-i];
						store_mem[cursor >> 3][cursor[2:0]] =
							store_mem[cursor >> 3][cursor[2:0]] | b;
						cursor++;
						i++;
					end
					r.bits_short = CNT_W'(n - i);
				end
			end
			ACT_FLUSH: begin
				if (cursor >= endb) r.status = STAT_FLUSH_END;
				else cursor = (cursor + 7) & ~32'd7;
			end
			ACT_RESTART: begin
				cursor = 0;
			end
			ACT_LOAD: begin
				if (addr < STORE_BYTES) store_mem[addr] = bval;
			end
			default: begin
				if (addr < STORE_BYTES) r.byte_out = store_mem[addr];
			end
		endcase
		r.position = cursor[POS_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor = 0;
			stream_len = STREAM_BYTES_RST;
			mode = MODE_BOTH;
			results_due.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_STREAM_BYTES) stream_len = cfg_wdata;
				else mode = cfg_wdata[MODE_W-1:0];
			end
			// compare before predicting so a same-edge command cannot hide a stray beat
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report("result beat with no command outstanding");
				end else begin
					due = results_due.pop_front();
					got = m_tdata;
					check_field("data_out", got.data_out, due.data_out);
					check_field("bits_short", got.bits_short, due.bits_short);
					check_field("status", got.status, due.status);
					check_field("byte_out", got.byte_out, due.byte_out);
					check_field("position", got.position, due.position);
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				fresh = bitstream_step(action_t'(s_tuser),
					s_tdata[IN_CNT_LSB +: CNT_W], s_tdata[IN_DATA_LSB +: DATA_W],
					s_tdata[IN_ADDR_LSB +: BADDR_W], s_tdata[IN_BVAL_LSB +: BYTE_W]);
				results_due.push_back(fresh);
				if (fresh.bits_short != 0) short_hits++;
				if (fresh.status == STAT_FORBIDDEN) forbid_hits++;
				if (fresh.status == STAT_FLUSH_END) flush_end_hits++;
			end
			outstanding = results_due.size();
		end
	end

endmodule

// File: verif/tb_bit_stream_reader_writer.sv
// ---------------------------------------------------------------------------
// tb_bit_stream_reader_writer
// Drives commands into the bit stream reader and writer with random gaps and
// output stalls: a short directed run over the edge cases, then random phases
// over several stream lengths and access modes. Every store byte is loaded
// before a bit access touches it. The scoreboard does all checking.
// ---------------------------------------------------------------------------
module tb_bit_stream_reader_writer;
	import bsrw_pkg::*;

	localparam int STORE_BYTES = 4096;
	// the unnamed fourth mode, which behaves as both
	localparam logic [MODE_W-1:0] MODE_BOTH_ALT = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [SB_W-1:0]      cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int fail_count, pending, bit_pos, n_checked, n_short, n_forbid, n_flush_end;

	bit loaded [STORE_BYTES];
	int loaded_q [$];
	int cur_sb = 0;
	int n_cmds = 0;
	int n_settings = 0;
	int act_hits [8];
	bit steady = 1'b0;

	bit_stream_reader_writer #(
		.STORE_BYTES(STORE_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bsrw_scoreboard #(
		.STORE_BYTES(STORE_BYTES)
	) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending),
		.bit_pos    (bit_pos),
		.n_checked  (n_checked),
		.n_short    (n_short),
		.n_forbid   (n_forbid),
		.n_flush_end(n_flush_end)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2500000;
		$display("bit_stream_reader_writer test failed");
		$finish;
	end

	// mostly back to back or short, now and then a long hold-off
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int stream_end();
		return ((cur_sb > STORE_BYTES) ? STORE_BYTES : cur_sb) * 8;
	endfunction

	// receiver: ready bursts of random length broken by stalls
	initial begin
		int run, stall;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				m_tready = 1'b1;
			end
			stall = gap_len();
			repeat (stall) begin
				@(negedge clk);
				m_tready = 1'b0;
			end
		end
	end

	// entered and left at a falling edge; the beat is held until taken
	task automatic send_cmd(input action_t act, input int cnt, input logic [DATA_W-1:0] din,
			input int addr, input int bval);
		int                   gap;
		logic [S_TDATA_W-1:0] beat;
		gap = steady ? 0 : gap_len();
		beat = '0;
		beat[IN_CNT_LSB +: CNT_W] = cnt[CNT_W-1:0];
		beat[IN_DATA_LSB +: DATA_W] = din;
		beat[IN_ADDR_LSB +: BADDR_W] = addr[BADDR_W-1:0];
		beat[IN_BVAL_LSB +: BYTE_W] = bval[BYTE_W-1:0];
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = beat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		n_cmds++;
		act_hits[act]++;
		if (act == ACT_LOAD && !loaded[addr]) begin
			loaded[addr] = 1'b1;
			loaded_q.push_back(addr);
		end
	endtask

	// loads every not yet loaded byte that a bit access of cnt bits will touch
	task automatic load_span(input int cnt);
		int n, stop, a;
		n = (cnt > MAX_BITS) ? MAX_BITS : cnt;
		stop = bit_pos + n;
		if (stop > stream_end()) stop = stream_end();
		if (stop > bit_pos) begin
			for (a = bit_pos >> 3; a <= (stop - 1) >> 3; a++) begin
				if (!loaded[a]) begin
					send_cmd(ACT_LOAD, 0, $urandom, a,
						($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255));
				end
			end
		end
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = SB_W'(val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_phase(input int sb, input logic [MODE_W-1:0] mode);
		drain();
		write_reg(CFG_STREAM_BYTES, sb);
		write_reg(CFG_ACCESS_MODE, int'(mode));
		cur_sb = sb;
		n_settings++;
	endtask

	task automatic random_command();
		int               r, cnt, addr, hi, len;
		logic [DATA_W-1:0] din;
		action_t          act;
		r = $urandom_range(0, 99);
		if (r < 15) act = ACT_RD_LSB;
		else if (r < 30) act = ACT_RD_MSB;
		else if (r < 44) act = ACT_WR_LSB;
		else if (r < 58) act = ACT_WR_MSB;
		else if (r < 66) act = ACT_FLUSH;
		else if (r < 72) act = ACT_RESTART;
		else if (r < 86) act = ACT_LOAD;
		else act = ACT_FETCH;
		// counts beyond the maximum now and then
		cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
		r = $urandom_range(0, 15);
		din = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
		addr = $urandom_range(0, STORE_BYTES - 1);
		case (act)
			ACT_RD_LSB, ACT_RD_MSB, ACT_WR_LSB, ACT_WR_MSB: begin
				load_span(cnt);
			end
			ACT_LOAD: begin
				if ($urandom_range(0, 3) != 0) begin
					len = (cur_sb > STORE_BYTES) ? STORE_BYTES : cur_sb;
					hi = (len + 1 > STORE_BYTES - 1) ? STORE_BYTES - 1 : len + 1;
					addr = $urandom_range(0, hi);
				end
			end
			ACT_FETCH: begin
				if (loaded_q.size() == 0) send_cmd(ACT_LOAD, 0, din, addr, $urandom_range(0, 255));
				addr = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
			end
			default: ;
		endcase
		send_cmd(act, cnt, din, addr,
			($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255));
	endtask

	task automatic random_phase(input int sb, input logic [MODE_W-1:0] mode, input int items);
		int k;
		set_phase(sb, mode);
		for (k = 0; k < items; k++) begin
			if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 149) == 0) drain();
			random_command();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty stream straight out of reset
		send_cmd(ACT_RD_LSB, 8, 32'h0, 0, 0);
		send_cmd(ACT_FLUSH, 0, 32'h0, 0, 0);

		set_phase(4, MODE_BOTH);
		send_cmd(ACT_LOAD, 0, 32'h0, 0, 8'hA5);
		send_cmd(ACT_LOAD, 0, 32'h0, 1, 8'h00);
		send_cmd(ACT_LOAD, 0, 32'h0, 2, 8'hFF);
		send_cmd(ACT_LOAD, 0, 32'h0, 3, 8'h3C);
		send_cmd(ACT_FETCH, 0, 32'h0, 3, 0);
		send_cmd(ACT_RD_LSB, 0, 32'hFFFF_FFFF, 0, 0);
		send_cmd(ACT_RD_LSB, 3, 32'h0, 0, 0);
		send_cmd(ACT_FLUSH, 0, 32'h0, 0, 0);
		// count above the maximum, runs off the end of the stream
		send_cmd(ACT_RD_MSB, 63, 32'hFFFF_FFFF, 0, 0);
		send_cmd(ACT_FLUSH, 0, 32'h0, 0, 0);
		send_cmd(ACT_WR_LSB, 5, 32'h1F, 0, 0);
		send_cmd(ACT_RESTART, 0, 32'h0, 0, 0);
		send_cmd(ACT_WR_LSB, 32, 32'h8421_1248, 0, 0);
		send_cmd(ACT_RESTART, 0, 32'h0, 0, 0);
		send_cmd(ACT_WR_MSB, 12, 32'hFFFF_FABC, 0, 0);
		send_cmd(ACT_RD_MSB, 32, 32'h0, 0, 0);
		send_cmd(ACT_RESTART, 0, 32'h0, 0, 0);

		set_phase(4, MODE_RD_ONLY);
		send_cmd(ACT_WR_MSB, 8, 32'hFF, 0, 0);
		send_cmd(ACT_RD_LSB, 32, 32'h0, 0, 0);

		set_phase(4, MODE_WR_ONLY);
		send_cmd(ACT_RD_LSB, 1, 32'h0, 0, 0);
		send_cmd(ACT_RESTART, 0, 32'h0, 0, 0);
		send_cmd(ACT_WR_MSB, 1, 32'h1, 0, 0);
		send_cmd(ACT_LOAD, 0, 32'h0, STORE_BYTES - 1, 8'hFF);
		send_cmd(ACT_FETCH, 0, 32'h0, STORE_BYTES - 1, 0);

		random_phase(16, MODE_BOTH, 250);
		random_phase(0, MODE_BOTH, 40);
		random_phase(1, MODE_RD_ONLY, 100);
		random_phase(6, MODE_WR_ONLY, 100);
		// stream length beyond the store is cut to the store
		random_phase(8191, MODE_BOTH_ALT, 150);
		random_phase(STORE_BYTES, MODE_BOTH, 150);
		while (n_cmds < 2000) begin
			random_phase($urandom_range(1, 48), MODE_W'($urandom_range(0, 3)), 150);
		end
		drain();

		$display("%0d cmds, %0d settings: rd %0d/%0d wr %0d/%0d fl %0d rs %0d ld %0d fe %0d",
			n_cmds, n_settings, act_hits[ACT_RD_LSB], act_hits[ACT_RD_MSB],
			act_hits[ACT_WR_LSB], act_hits[ACT_WR_MSB], act_hits[ACT_FLUSH],
			act_hits[ACT_RESTART], act_hits[ACT_LOAD], act_hits[ACT_FETCH]);
		$display("%0d checked: %0d cut short, %0d refused by mode, %0d flushes at the end",
			n_checked, n_short, n_forbid, n_flush_end);
		if (fail_count == 0) begin
			$display("bit_stream_reader_writer test passed");
		end else begin
			$display("bit_stream_reader_writer test failed");
		end
		$finish;
	end

endmodule
